// ===== rtl/core/hermi_pkg.sv =====
// Shared types and constants for the Hermite interpolator core.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package hermi_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TENSION = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BIAS    = 1'b1;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Q2.14 weights grow by one bit once 1.0 is added or subtracted
  localparam int unsigned WEIGHT_BITS = CFG_DATA_BITS + 1;
  localparam logic signed [WEIGHT_BITS-1:0] Q_ONE = 17'sd16384;
  localparam int unsigned Q_FRAC = 14;

  // Internal scale: samples carry (SCALE_BITS - sample width) guard bits
  localparam int unsigned SCALE_BITS   = 32;
  localparam int unsigned TAN_BITS     = 38;  // inner tangent sum after scaling
  localparam int unsigned SLOPE_BITS   = 40;  // end tangent
  localparam int unsigned HORNER_BITS  = 42;  // polynomial coefficients and accumulator

  // Back pipeline depth and the most words the core can hold at once
  localparam int unsigned BACK_STAGES   = 12;
  localparam int unsigned ITEM_CAPACITY = BACK_STAGES + 3;
  localparam int unsigned FRONT_BACKLOG = 3;  // front register plus a full queue

  // Queue status seen by the front and back halves
  typedef struct packed {
    logic empty;
    logic full;
  } hermi_q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/hermi_front.sv =====
// Front half: takes sample words, forms neighbor differences, pushes the queue.
// Depends on hermi_pkg.
`default_nettype none

module hermi_front
  import hermi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_before,
  input  logic signed [SAMPLE_BITS-1:0] sample_start,
  input  logic signed [SAMPLE_BITS-1:0] sample_end,
  input  logic signed [SAMPLE_BITS-1:0] sample_after,
  input  logic        [FRAC_BITS-1:0]   position,
  input  hermi_q_status_t               q_status,
  output logic                          push,
  output logic [3*(SAMPLE_BITS+1)+2*SAMPLE_BITS+FRAC_BITS-1:0] entry
);

  localparam int DW = SAMPLE_BITS + 1;

  logic                          held;
  logic                          load;
  logic signed [DW-1:0]          d1;
  logic signed [DW-1:0]          d2;
  logic signed [DW-1:0]          d3;
  logic signed [SAMPLE_BITS-1:0] y2;
  logic signed [SAMPLE_BITS-1:0] y3;
  logic        [FRAC_BITS-1:0]   pos;

  // Move the held word on whenever the queue has room
  assign push         = held && !q_status.full;
  assign sample_stall = held && q_status.full;
  assign load         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Capture differences and the two inner samples
  always_ff @(posedge clk) begin
    if (load) begin
      d1  <= DW'(sample_start) - DW'(sample_before);
      d2  <= DW'(sample_end) - DW'(sample_start);
      d3  <= DW'(sample_after) - DW'(sample_end);
      y2  <= sample_start;
      y3  <= sample_end;
      pos <= position;
    end
  end

  assign entry = {d1, d2, d3, y2, y3, pos};

endmodule

`default_nettype wire

// ===== rtl/core/hermi_fifo.sv =====
// Two-entry queue between the front and back halves.
// Depends on hermi_pkg for the status struct.
`default_nettype none

module hermi_fifo
  import hermi_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output hermi_q_status_t  status
);

  logic [WIDTH-1:0] slot [0:1];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign rd_data      = slot[rd_ptr];
  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);

  // Track occupancy and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hermi_mac.sv =====
// Two-stage split multiply, round and add: result = addend + round(a * b / 2^SHIFT).
// The wide operand is cut in two halves; depends on hermi_pkg.
`default_nettype none

module hermi_mac
  import hermi_pkg::*;
#(
  parameter int A_BITS   = 42,
  parameter int B_BITS   = 17,
  parameter int R_BITS   = 42,
  parameter int SHIFT    = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [A_BITS-1:0] a,
  input  logic signed [B_BITS-1:0] b,
  input  logic signed [R_BITS-1:0] addend,
  output logic signed [R_BITS-1:0] result
);

  localparam int LO = (A_BITS + 1) / 2;
  localparam int HI = A_BITS - LO;
  localparam int PW = A_BITS + B_BITS;
  localparam int FW = ((PW > R_BITS) ? PW : R_BITS) + 1;

  logic signed [LO+B_BITS:0]   prod_lo;
  logic signed [HI+B_BITS-1:0] prod_hi;
  logic signed [R_BITS-1:0]    addend_q;
  logic signed [FW-1:0]        full;
  logic signed [FW-1:0]        rounded;

  // Register the two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo  <= $signed({1'b0, a[LO-1:0]}) * b;
      prod_hi  <= $signed(a[A_BITS-1:LO]) * b;
      addend_q <= addend;
    end
  end

  // Recombine, round half up, add
  always_comb begin
    full    = (FW'(prod_hi) <<< LO) + FW'(prod_lo);
    rounded = (full + (FW'(1) <<< (SHIFT - 1))) >>> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= addend_q + $signed(rounded[R_BITS-1:0]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hermi_back.sv =====
// Back half: tangents, Hermite coefficients, three Horner steps, round and saturate.
// Depends on hermi_pkg and hermi_mac.
`default_nettype none

module hermi_back
  import hermi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hermi_q_status_t               q_status,
  input  logic [3*(SAMPLE_BITS+1)+2*SAMPLE_BITS+FRAC_BITS-1:0] entry,
  output logic                          pop,
  input  logic signed [CFG_DATA_BITS-1:0] tension,
  input  logic signed [CFG_DATA_BITS-1:0] bias,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] interpolated
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int DW    = S + 1;
  localparam int PW    = DW + WEIGHT_BITS;
  localparam int IW    = PW + 1;
  localparam int GUARD = SCALE_BITS - S;
  localparam int XW    = IW + GUARD + 1;
  localparam int HW    = HORNER_BITS;
  localparam int RXW   = HW + 2;
  localparam logic signed [RXW-1:0] SAT_HI = RXW'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [RXW-1:0] SAT_LO = RXW'(-(64'sd1 <<< (S - 1)));

  // Queue word fields
  logic signed [DW-1:0] e_d1, e_d2, e_d3;
  logic signed [S-1:0]  e_y2, e_y3;
  logic        [F-1:0]  e_p;

  assign e_p  = entry[F-1:0];
  assign e_y3 = entry[F+S-1:F];
  assign e_y2 = entry[F+2*S-1:F+S];
  assign e_d3 = entry[F+2*S+DW-1:F+2*S];
  assign e_d2 = entry[F+2*S+2*DW-1:F+2*S+DW];
  assign e_d1 = entry[F+2*S+3*DW-1:F+2*S+2*DW];

  logic                         en;
  logic [BACK_STAGES-1:0]       v;
  logic signed [WEIGHT_BITS-1:0] wp, wn, wt;

  // Whole pipe advances unless a finished word waits at the output
  assign en           = !(v[BACK_STAGES-1] && result_stall);
  assign pop          = en && !q_status.empty;
  assign result_valid = v[BACK_STAGES-1];

  assign wp = Q_ONE + WEIGHT_BITS'(bias);
  assign wn = Q_ONE - WEIGHT_BITS'(bias);
  assign wt = Q_ONE - WEIGHT_BITS'(tension);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[BACK_STAGES-2:0], pop};
    end
  end

  // Carry lines for samples, position and first tangent
  logic signed [S-1:0]          y2_q [0:8];
  logic signed [S-1:0]          y3_q [0:3];
  logic        [F-1:0]          p_q  [0:8];
  logic signed [SLOPE_BITS-1:0] m1_q [4:6];

  always_ff @(posedge clk) begin
    if (en) begin
      y2_q[0] <= e_y2;
      y3_q[0] <= e_y3;
      p_q[0]  <= e_p;
      for (int k = 1; k <= 8; k++) begin
        y2_q[k] <= y2_q[k-1];
        p_q[k]  <= p_q[k-1];
      end
      for (int k = 1; k <= 3; k++) begin
        y3_q[k] <= y3_q[k-1];
      end
    end
  end

  // Stage 0: bias-weighted differences
  logic signed [PW-1:0] pa1, pb1, pa2, pb2;

  always_ff @(posedge clk) begin
    if (en) begin
      pa1 <= wp * e_d1;
      pb1 <= wn * e_d2;
      pa2 <= wp * e_d2;
      pb2 <= wn * e_d3;
    end
  end

  // Stage 1: inner sums, scaled to internal units with rounding
  logic signed [IW-1:0]       inner1, inner2;
  logic signed [XW-1:0]       scaled1, scaled2;
  logic signed [TAN_BITS-1:0] h1, h2;

  always_comb begin
    inner1  = IW'(pa1) + IW'(pb1);
    inner2  = IW'(pa2) + IW'(pb2);
    scaled1 = ((XW'(inner1) <<< GUARD) + (XW'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
    scaled2 = ((XW'(inner2) <<< GUARD) + (XW'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1 <= TAN_BITS'(scaled1);
      h2 <= TAN_BITS'(scaled2);
    end
  end

  // Stages 2-3: tension weighting
  logic signed [SLOPE_BITS-1:0] m1, m2;

  hermi_mac #(
    .A_BITS(TAN_BITS), .B_BITS(WEIGHT_BITS), .R_BITS(SLOPE_BITS), .SHIFT(Q_FRAC + 1)
  ) u_tan1 (
    .clk(clk), .en(en), .a(h1), .b(wt), .addend('0), .result(m1)
  );

  hermi_mac #(
    .A_BITS(TAN_BITS), .B_BITS(WEIGHT_BITS), .R_BITS(SLOPE_BITS), .SHIFT(Q_FRAC + 1)
  ) u_tan2 (
    .clk(clk), .en(en), .a(h2), .b(wt), .addend('0), .result(m2)
  );

  // Stage 4: cubic and quadratic coefficients
  logic signed [HW-1:0] s2, s3, m1x, m2x, c3, c2;

  always_comb begin
    s2  = HW'(y2_q[3]) <<< GUARD;
    s3  = HW'(y3_q[3]) <<< GUARD;
    m1x = HW'(m1);
    m2x = HW'(m2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3      <= (s2 <<< 1) - (s3 <<< 1) + m1x + m2x;
      c2      <= (s3 <<< 1) + s3 - (s2 <<< 1) - s2 - (m1x <<< 1) - m2x;
      m1_q[4] <= m1;
      m1_q[5] <= m1_q[4];
      m1_q[6] <= m1_q[5];
    end
  end

  // Stages 5-10: Horner steps
  logic signed [HW-1:0] acc1, acc2, acc3;
  logic signed [HW-1:0] s2_late;

  assign s2_late = HW'(y2_q[8]) <<< GUARD;

  hermi_mac #(
    .A_BITS(HW), .B_BITS(F + 1), .R_BITS(HW), .SHIFT(F)
  ) u_horner1 (
    .clk(clk), .en(en), .a(c3), .b($signed({1'b0, p_q[4]})), .addend(c2), .result(acc1)
  );

  hermi_mac #(
    .A_BITS(HW), .B_BITS(F + 1), .R_BITS(HW), .SHIFT(F)
  ) u_horner2 (
    .clk(clk), .en(en), .a(acc1), .b($signed({1'b0, p_q[6]})), .addend(HW'(m1_q[6])),
    .result(acc2)
  );

  hermi_mac #(
    .A_BITS(HW), .B_BITS(F + 1), .R_BITS(HW), .SHIFT(F)
  ) u_horner3 (
    .clk(clk), .en(en), .a(acc2), .b($signed({1'b0, p_q[8]})), .addend(s2_late),
    .result(acc3)
  );

  // Stage 11: drop guard bits with rounding, then saturate
  logic signed [RXW-1:0] rx;

  assign rx = (RXW'($signed({acc3, 1'b0})) + (RXW'(1) <<< GUARD)) >>> (GUARD + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (rx > SAT_HI) begin
        interpolated <= SAT_HI[S-1:0];
      end else if (rx < SAT_LO) begin
        interpolated <= SAT_LO[S-1:0];
      end else begin
        interpolated <= rx[S-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hermite_interpolator_core.sv =====
// Hermite interpolator with tension and bias: top level.
// An accepted sample word passes the front register and the two-entry queue into the back pipe.
// Throughput: one word per cycle when result_stall is low; set by the twelve-stage back
//   pipe, where the tangent and each Horner step use a two-stage split multiplier.
// Reset: clears the valid bits, the two-entry queue and tension and bias to zero.
// Depends on hermi_pkg, hermi_front, hermi_fifo, hermi_mac, hermi_back.
`default_nettype none

module hermite_interpolator_core
  import hermi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_before,
  input  logic signed [SAMPLE_BITS-1:0] sample_start,
  input  logic signed [SAMPLE_BITS-1:0] sample_end,
  input  logic signed [SAMPLE_BITS-1:0] sample_after,
  input  logic        [FRAC_BITS-1:0]   position,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] interpolated
);

  localparam int QW = 3 * (SAMPLE_BITS + 1) + 2 * SAMPLE_BITS + FRAC_BITS;

  logic signed [CFG_DATA_BITS-1:0] tension;
  logic signed [CFG_DATA_BITS-1:0] bias;
  logic                            push;
  logic                            pop;
  logic [QW-1:0]                   wr_entry;
  logic [QW-1:0]                   rd_entry;
  hermi_q_status_t                 q_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= '0;
      bias    <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TENSION: tension <= $signed(cfg_data);
        CFG_BIAS:    bias    <= $signed(cfg_data);
      endcase
    end
  end

  hermi_front #(
    .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_before(sample_before), .sample_start(sample_start),
    .sample_end(sample_end), .sample_after(sample_after), .position(position),
    .q_status(q_status), .push(push), .entry(wr_entry)
  );

  hermi_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wr_data(wr_entry),
    .pop(pop), .rd_data(rd_entry), .status(q_status)
  );

  hermi_back #(
    .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_status(q_status), .entry(rd_entry), .pop(pop),
    .tension(tension), .bias(bias),
    .result_valid(result_valid), .result_stall(result_stall),
    .interpolated(interpolated)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hermi_checker.sv =====
// Port-level checks for the Hermite interpolator core, bound to the top level.
// Depends on hermi_pkg.
`default_nettype none

module hermi_checker
  import hermi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic signed [SAMPLE_BITS-1:0] interpolated
);

  localparam int CW = $clog2(ITEM_CAPACITY + 1);

  logic          in_take;
  logic          out_take;
  logic [CW-1:0] outstanding;

  assign in_take  = sample_valid && !sample_stall;
  assign out_take = result_valid && !result_stall;

  // Count words accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      unique case ({in_take, out_take})
        2'b10:   outstanding <= outstanding + CW'(1);
        2'b01:   outstanding <= outstanding - CW'(1);
        default: outstanding <= outstanding;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(interpolated))
    else $error("result word changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_take |-> outstanding != '0)
    else $error("result word without a pending sample word");

  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> outstanding >= CW'(FRONT_BACKLOG))
    else $error("input stalled with the queue not full");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CW'(ITEM_CAPACITY))
    else $error("more words in flight than the core can hold");

endmodule

bind hermite_interpolator_core hermi_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_hermi_checker (.*);

`default_nettype wire
